>>> design/roimean_pkg.sv
// ----------------------------------------------------------------------------
// roimean_pkg
// Shared widths, register map and reset values of the region-of-interest
// mean block.
// ----------------------------------------------------------------------------
package roimean_pkg;

  // channel payload widths
  localparam int PIXEL_W = 16;

  // accumulator widths
  localparam int SUM_W = 40;
  localparam int CNT_W = 25;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int WIDTH_W = 13;
  localparam int CCOL_W  = 12;
  localparam int CROW_W  = 12;
  localparam int SIZE_W  = 13;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 13'd1920;
  localparam logic [CCOL_W-1:0]  CCOL_RST  = 12'd960;
  localparam logic [CROW_W-1:0]  CROW_RST  = 12'd1773;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 13'd100;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_CENTER_COLUMN = 2'd1,
    REG_CENTER_ROW    = 2'd2,
    REG_REGION_SIZE   = 2'd3
  } reg_idx_t;

endpackage

>>> design/roimean_if.sv
// ----------------------------------------------------------------------------
// roimean channel interfaces
// Valid/ready channels for the pixel stream and for the mean results.
// ----------------------------------------------------------------------------
interface roimean_in_if;
  import roimean_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_end;

  modport source (output valid, pixel, frame_end, input ready);
  modport sink   (input valid, pixel, frame_end, output ready);
endinterface

interface roimean_out_if;
  import roimean_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] mean_value;
  logic               window_empty;

  modport source (output valid, mean_value, window_empty, input ready);
  modport sink   (input valid, mean_value, window_empty, output ready);
endinterface

>>> design/roi_mean_rounded_top.sv
// Result: a frame end beat is followed by a result after the setup state,
//   PIXEL_BITS+1 divider steps and the output load.
// Throughput: one pixel per cycle inside a frame; after each frame end the input
//   stalls until its result is loaded, longer while an earlier result waits.
// Reset: synchronous active-low rst_n clears counters, accumulators and valids
//   and loads the register defaults.
// ----------------------------------------------------------------------------
// roi_mean_rounded_top
// Sums pixels of a square window in a raster stream and outputs the rounded
// mean on each frame end through a bit-serial divider.
// ----------------------------------------------------------------------------
module roi_mean_rounded_top #(
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  roimean_in_if.sink                  in_if,
  roimean_out_if.source               out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [roimean_pkg::ADDR_W-1:0] paddr,
  input  logic [roimean_pkg::DATA_W-1:0] pwdata,
  output logic [roimean_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import roimean_pkg::*;

  localparam int CMP_W  = COORD_BITS + 2;
  localparam int WID_W  = (COORD_BITS + 2 > WIDTH_W + 1) ? COORD_BITS + 2 : WIDTH_W + 1;
  localparam int NUM_W  = SUM_W + 2;
  localparam int DEN_W  = CNT_W + 1 + PIXEL_BITS;
  localparam int DIV_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int QW     = PIXEL_BITS + 1;
  localparam int STEP_W = $clog2(PIXEL_BITS + 1);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [PIXEL_BITS-1:0] PIX_MAX   = {PIXEL_BITS{1'b1}};
  localparam logic [SUM_W-1:0]      SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]      CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // configuration registers
  logic [WIDTH_W-1:0] width_r;
  logic [CCOL_W-1:0]  ccol_r;
  logic [CROW_W-1:0]  crow_r;
  logic [SIZE_W-1:0]  size_r;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:   prdata = DATA_W'(width_r);
      REG_CENTER_COLUMN: prdata = DATA_W'(ccol_r);
      REG_CENTER_ROW:    prdata = DATA_W'(crow_r);
      REG_REGION_SIZE:   prdata = DATA_W'(size_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
      ccol_r  <= CCOL_RST;
      crow_r  <= CROW_RST;
      size_r  <= SIZE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:   width_r <= pwdata[WIDTH_W-1:0];
        REG_CENTER_COLUMN: ccol_r  <= pwdata[CCOL_W-1:0];
        REG_CENTER_ROW:    crow_r  <= pwdata[CROW_W-1:0];
        REG_REGION_SIZE:   size_r  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath state
  state_t                state_r, state_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_W-1:0]      dsh_r, dsh_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  empty_r, empty_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]    out_mean_r, out_mean_nxt;
  logic                  out_empty_r, out_empty_nxt;

  // window test
  logic [COORD_BITS-1:0] ccol_m, crow_m;
  logic [COORD_BITS:0]   size_m;
  logic [CMP_W-1:0]      half;
  logic                  in_col, in_row;
  logic                  beat;
  logic [PIXEL_BITS-1:0] pix;
  logic [SUM_W:0]        sum_add;
  logic [WID_W-1:0]      col_p1;
  logic                  wrap;
  logic                  ge;
  logic [PIXEL_BITS-1:0] res_mean;

  assign ccol_m = COORD_BITS'(ccol_r);
  assign crow_m = COORD_BITS'(crow_r);
  assign size_m = (COORD_BITS + 1)'(size_r);
  assign half   = CMP_W'(size_m >> 1);

  // start <= p <= end, rewritten without negatives
  assign in_col = (CMP_W'(col_r) + half >= CMP_W'(ccol_m)) &&
                  (CMP_W'(col_r) < CMP_W'(ccol_m) + half);
  assign in_row = (CMP_W'(row_r) + half >= CMP_W'(crow_m)) &&
                  (CMP_W'(row_r) < CMP_W'(crow_m) + half);

  assign beat    = in_if.valid && in_if.ready;
  assign pix     = in_if.pixel[PIXEL_BITS-1:0];
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(pix);
  assign col_p1  = WID_W'(col_r) + WID_W'(1);
  assign wrap    = (col_p1 >= WID_W'(width_r)) || (col_r == COORD_MAX);
  assign ge      = (rem_r >= dsh_r);

  assign res_mean = empty_r ? '0 : (quo_r[PIXEL_BITS] ? PIX_MAX : quo_r[PIXEL_BITS-1:0]);

  assign in_if.ready         = (state_r == ST_ACC);
  assign out_if.valid        = out_valid_r;
  assign out_if.mean_value   = out_mean_r;
  assign out_if.window_empty = out_empty_r;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_mean_nxt  = out_mean_r;
    out_empty_nxt = out_empty_r;

    case (state_r)
      ST_ACC: begin
        if (beat) begin
          if (in_col && in_row) begin
            sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            if (cnt_r != CNT_MAX) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          if (in_if.frame_end) begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_PREP;
          end else if (wrap) begin
            col_nxt = '0;
            row_nxt = row_r + COORD_BITS'(1);
          end else begin
            col_nxt = col_r + COORD_BITS'(1);
          end
        end
      end
      ST_PREP: begin
        // numerator 2*sum+count, divisor 2*count aligned to the top quotient bit
        rem_nxt   = DIV_W'({sum_r, 1'b0}) + DIV_W'(cnt_r);
        dsh_nxt   = DIV_W'({cnt_r, 1'b0}) << PIXEL_BITS;
        quo_nxt   = '0;
        step_nxt  = STEP_W'(PIXEL_BITS);
        empty_nxt = (cnt_r == '0);
        sum_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        quo_nxt = {quo_r[PIXEL_BITS-1:0], ge};
        dsh_nxt = dsh_r >> 1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = PIXEL_W'(res_mean);
          out_empty_nxt = empty_r;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    quo_r       <= quo_nxt;
    out_mean_r  <= out_mean_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // a frame end beat always starts the divider
  a_frame_end_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && in_if.frame_end) |=> (state_r == ST_PREP))
    else $error("frame end did not start the divider");

  // the sum is zero whenever the count is zero
  a_sum_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("window sum nonzero with zero count");

  // an empty window reports a zero mean
  a_empty_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_mean_r == '0))
    else $error("empty window with nonzero mean");

  // accumulators are clear while the divider runs
  a_acc_clear_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (sum_r == '0 && cnt_r == '0 && col_r == '0 && row_r == '0))
    else $error("accumulator not cleared during divide");

  // a result is loaded only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside done state");

endmodule

>>> tb/roimean_mean_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// roimean_mean_chk
// Watches the pixel, result and register ports of the region-of-interest
// mean block, tracks column, row, window sum and count itself, and compares
// every result beat against the oldest predicted mean.
// ----------------------------------------------------------------------------
module roimean_mean_chk
  import roimean_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  roimean_in_if             in_ch,
  roimean_out_if            out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mism_count,
  output int                owed
);

  localparam longint unsigned SUM_TOP   = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned PIXEL_TOP = (64'd1 << PIXEL_W) - 64'd1;

  typedef struct packed {
    logic [PIXEL_W-1:0] mean_value;
    logic               window_empty;
  } roi_mean_t;

  roi_mean_t pending_means[$];
  roi_mean_t seen;
  roi_mean_t want;

  logic [WIDTH_W-1:0] img_width;
  logic [CCOL_W-1:0]  ctr_col;
  logic [CROW_W-1:0]  ctr_row;
  logic [SIZE_W-1:0]  roi_size;

  logic [CCOL_W-1:0]  col_pos;
  logic [CROW_W-1:0]  row_pos;
  logic [SUM_W-1:0]   acc_sum;
  logic [CNT_W-1:0]   acc_cnt;

  function automatic bit in_window(input int pos, input int ctr);
    int half;
    half = int'(roi_size >> 1);
    return (pos >= ctr - half) && (pos <= ctr + half - 1);
  endfunction

  task automatic accumulate_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    roi_mean_t res;
    if (in_window(int'(col_pos), int'(ctr_col)) && in_window(int'(row_pos), int'(ctr_row)))
    begin
      if (64'(acc_sum) + 64'(pix) > SUM_TOP) acc_sum = '1;
      else acc_sum = acc_sum + SUM_W'(pix);
      if (acc_cnt != '1) acc_cnt = acc_cnt + CNT_W'(1);
    end
    // width 0 acts as 1, column also wraps at its own range
    if (int'(col_pos) + 1 >= int'(img_width) || col_pos == '1) begin
      col_pos = '0;
      row_pos = row_pos + CROW_W'(1);
    end else begin
      col_pos = col_pos + CCOL_W'(1);
    end
    if (last) begin
      if (acc_cnt == '0) begin
        res.mean_value   = '0;
        res.window_empty = 1'b1;
      end else begin
        num = 2 * 64'(acc_sum) + 64'(acc_cnt);
        den = 2 * 64'(acc_cnt);
        q   = num / den;
        if (q > PIXEL_TOP) q = PIXEL_TOP;
        res.mean_value   = q[PIXEL_W-1:0];
        res.window_empty = 1'b0;
      end
      pending_means.push_back(res);
      acc_sum = '0;
      acc_cnt = '0;
      col_pos = '0;
      row_pos = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      img_width  = WIDTH_RST;
      ctr_col    = CCOL_RST;
      ctr_row    = CROW_RST;
      roi_size   = SIZE_RST;
      col_pos    = '0;
      row_pos    = '0;
      acc_sum    = '0;
      acc_cnt    = '0;
      mism_count = 0;
      pending_means.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_IMAGE_WIDTH:   img_width = pwdata[WIDTH_W-1:0];
          REG_CENTER_COLUMN: ctr_col   = pwdata[CCOL_W-1:0];
          REG_CENTER_ROW:    ctr_row   = pwdata[CROW_W-1:0];
          REG_REGION_SIZE:   roi_size  = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) accumulate_pixel(in_ch.pixel, in_ch.frame_end);
      if (out_ch.valid && out_ch.ready) begin
        seen.mean_value   = out_ch.mean_value;
        seen.window_empty = out_ch.window_empty;
        if (pending_means.size() == 0) begin
          $display("%0t: result beat with no frame pending: mean %h empty %b",
                   $time, seen.mean_value, seen.window_empty);
          mism_count++;
        end else begin
          want = pending_means.pop_front();
          if (seen.mean_value !== want.mean_value) begin
            $display("%0t: mean_value expected %h actual %h",
                     $time, want.mean_value, seen.mean_value);
            mism_count++;
          end
          if (seen.window_empty !== want.window_empty) begin
            $display("%0t: window_empty expected %b actual %b",
                     $time, want.window_empty, seen.window_empty);
            mism_count++;
          end
        end
      end
    end
    owed = pending_means.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel frames and register settings into the region-of-interest
// mean block with random gaps and back-pressure, and reports the verdict
// from the mean checker.
// ----------------------------------------------------------------------------
module tb_top;
  import roimean_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  roimean_in_if  in_bus ();
  roimean_out_if out_bus ();

  int mism_count;
  int owed;
  int pixels_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeezed = 1'b0;
  int hold_left = 0;

  always #2 clk = ~clk;

  roi_mean_rounded_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  roimean_mean_chk u_mean_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .pready     (cfg_pready),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .mism_count (mism_count),
    .owed       (owed)
  );

  // stalls on the result side, plus one long hold-off to fill the block
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left == 0 && squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly small values so windows land inside small frames
  function automatic int pick_field(input int full_max, input int small_max);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return full_max;
      2:       return $urandom_range(0, full_max);
      3:       return (full_max + 1) / 2;
      default: return $urandom_range(0, small_max);
    endcase
  endfunction

  task automatic push_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.pixel     <= pix;
    in_bus.frame_end <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      if (pixels_sent >= 500) begin
        squeeze_req = 1'b1;
      end
      push_pixel(pick_pixel(), i == len - 1);
    end
  endtask

  // wait for every owed mean, then for the divider to go quiet
  task automatic drain_block();
    in_bus.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (PIXEL_W + 8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int w, input int cc, input int cr, input int sz);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
    write_reg(REG_CENTER_COLUMN, DATA_W'(cc));
    write_reg(REG_CENTER_ROW, DATA_W'(cr));
    write_reg(REG_REGION_SIZE, DATA_W'(sz));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int n_frames;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.pixel     = '0;
    in_bus.frame_end = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window lies far outside a two-pixel frame: empty
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b1);

    // zero width: each pixel is its own row, only the first one counts
    configure(0, 0, 0, 2);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'h0002, 1'b1);

    // mean of 1 and 2 rounds half up
    configure(3, 1, 0, 3);
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'h0002, 1'b0);
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h8000, 1'b1);

    // size 0 and size 1 leave no span
    configure(3, 1, 0, 0);
    push_pixel(16'h1234, 1'b0);
    push_pixel(16'hFEDC, 1'b1);
    configure(3, 1, 0, 1);
    push_pixel(16'h5555, 1'b1);

    // largest settings, window covers everything
    configure(4096, 4095, 4095, 8191);
    push_pixel(16'hAAAA, 1'b0);
    push_pixel(16'h5555, 1'b0);
    push_pixel(16'hFFFF, 1'b1);

    while (pixels_sent < 1450) begin
      configure(pick_field(8191, 16), pick_field(4095, 16),
                pick_field(4095, 10), pick_field(8191, 24));
      n_frames = $urandom_range(2, 6);
      repeat (n_frames) begin
        no_idle = (pixels_sent >= 900 && pixels_sent < 1200);
        send_frame($urandom_range(1, 48));
      end
    end
    no_idle = 1'b0;

    drain_block();
    if (mism_count == 0 && owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
